// File: src/pfb_pkg.sv
// Package for the page framebuffer text renderer: beat types, command codes,
// controller states and the glyph and symbol font tables. No dependencies.
`timescale 1ns / 1ps

package pfb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_PIXEL  = 3'd1,
        CMD_GLYPH  = 3'd2,
        CMD_SYMBOL = 3'd3,
        CMD_CURSOR = 3'd4,
        CMD_PRINT  = 3'd5,
        CMD_READ   = 3'd6,
        CMD_NONE   = 3'd7
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  x_pos;
        logic [7:0]  y_pos;
        logic [7:0]  char_code;
        logic [1:0]  symbol_sel;
        logic [9:0]  byte_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [7:0]  cursor_col;
        logic [7:0]  cursor_row;
        logic        text_halted;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_CLEAR,
        ST_LO_RD,
        ST_LO_WR,
        ST_HI_RD,
        ST_HI_WR,
        ST_NEXT_COL,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic clr_wr;
        logic lo_rd;
        logic lo_wr;
        logic hi_rd;
        logic hi_wr;
        logic col_step;
        logic rd_issue;
        logic rd_capture;
        logic finish;
    } t_dp_ctrl;

    // datapath -> controller
    typedef struct packed {
        t_cmd cmd;
        logic has_draw;
        logic clr_last;
        logic lo_need;
        logic hi_need;
        logic col_last;
    } t_dp_stat;

    localparam logic [7:0] GLYPH_ROM [0:28][0:4] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
        '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46},
        '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
        '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30},
        '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
        '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00},
        '{8'h00, 8'h66, 8'h66, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
        '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41},
        '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F},
        '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
        '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F},
        '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41},
        '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
        '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
        '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22},
        '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
        '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
        '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31},
        '{8'h7E, 8'h09, 8'h09, 8'h09, 8'h7E},
        '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36}
    };

    localparam logic [7:0] SYM_ROM [0:2][0:7] = '{
        '{8'h18, 8'h24, 8'h24, 8'h24, 8'h3C, 8'h3C, 8'h3C, 8'h18},
        '{8'h1E, 8'h3F, 8'h3F, 8'h7E, 8'h7C, 8'h78, 8'h70, 8'h60},
        '{8'h66, 8'hFF, 8'hFF, 8'h7E, 8'h3C, 8'h18, 8'h00, 8'h00}
    };

    // {valid, slot}; lower case folds to upper
    function automatic logic [5:0] glyph_slot(input logic [7:0] c);
        logic [7:0] u;
        logic [5:0] res;
        u = (c >= 8'h61 && c <= 8'h7A) ? (c - 8'h20) : c;
        res = 6'd0;
        if (u >= 8'h30 && u <= 8'h39) begin
            res = {1'b1, 5'(u - 8'h2F)};
        end else begin
            case (u)
                8'h2E: res = {1'b1, 5'd11};
                8'h3A: res = {1'b1, 5'd12};
                8'h20: res = {1'b1, 5'd13};
                8'h50: res = {1'b1, 5'd14};
                8'h45: res = {1'b1, 5'd15};
                8'h4D: res = {1'b1, 5'd16};
                8'h54: res = {1'b1, 5'd17};
                8'h55: res = {1'b1, 5'd18};
                8'h4B: res = {1'b1, 5'd19};
                8'h48: res = {1'b1, 5'd20};
                8'h44: res = {1'b1, 5'd21};
                8'h43: res = {1'b1, 5'd22};
                8'h4C: res = {1'b1, 5'd23};
                8'h4E: res = {1'b1, 5'd24};
                8'h52: res = {1'b1, 5'd25};
                8'h53: res = {1'b1, 5'd26};
                8'h41: res = {1'b1, 5'd27};
                8'h42: res = {1'b1, 5'd28};
                default: res = 6'd0;
            endcase
        end
        return res;
    endfunction

    function automatic logic [7:0] glyph_col(input logic [4:0] slot, input logic [2:0] col);
        logic [7:0] res;
        res = 8'd0;
        if (slot <= 5'd28 && col <= 3'd4) begin
            res = GLYPH_ROM[slot][col];
        end
        return res;
    endfunction

    // symbol rows are MSB first; transpose into one column byte
    function automatic logic [7:0] sym_col(input logic [1:0] sel, input logic [2:0] col);
        logic [7:0] res;
        res = 8'd0;
        if (sel <= 2'd2) begin
            for (int i = 0; i < 8; i++) begin
                res[i] = SYM_ROM[sel][i][3'd7 - col];
            end
        end
        return res;
    endfunction

endpackage

// File: src/page_framebuffer_text_renderer.sv
// One command in flight; cost is set by the single store port: each touched
// byte is a read then a write.
// A new beat is taken in idle, once the result of the last one is registered;
// completion waits while the output still holds an untaken result.
// Reset (sync, active low) runs a clearing pass over all W*pages bytes (1024 by
// default) of the frame store before the first beat is accepted.
`timescale 1ns / 1ps

module page_framebuffer_text_renderer
    import pfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_dp_ctrl ctl;
    t_dp_stat stat;

    pfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    pfb_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_ctl      (ctl),
        .o_stat     (stat),
        .o_out_item (o_out_item)
    );

endmodule

// File: src/pfb_ram.sv
// Generic single-clock RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/pfb_ctrl.sv
// Command sequencer for the page framebuffer renderer.
// Depends on pfb_pkg; drives pfb_datapath through t_dp_ctrl.
`timescale 1ns / 1ps

module pfb_ctrl
    import pfb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctl
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT:     n_state = i_stat.clr_last ? ST_IDLE : ST_INIT;
            ST_IDLE:     n_state = i_in_valid ? ST_DISPATCH : ST_IDLE;
            ST_DISPATCH: begin
                case (i_stat.cmd)
                    CMD_CLEAR:  n_state = ST_CLEAR;
                    CMD_PIXEL,
                    CMD_GLYPH,
                    CMD_SYMBOL,
                    CMD_PRINT:  n_state = i_stat.has_draw ? ST_LO_RD : ST_DONE;
                    CMD_READ:   n_state = ST_RD_ISSUE;
                    default:    n_state = ST_DONE;
                endcase
            end
            ST_CLEAR:    n_state = i_stat.clr_last ? ST_DONE : ST_CLEAR;
            ST_LO_RD:    n_state = i_stat.lo_need ? ST_LO_WR : ST_HI_RD;
            ST_LO_WR:    n_state = ST_HI_RD;
            ST_HI_RD:    n_state = i_stat.hi_need ? ST_HI_WR : ST_NEXT_COL;
            ST_HI_WR:    n_state = ST_NEXT_COL;
            ST_NEXT_COL: n_state = i_stat.col_last ? ST_DONE : ST_LO_RD;
            ST_RD_ISSUE: n_state = ST_RD_WAIT;
            ST_RD_WAIT:  n_state = ST_DONE;
            ST_DONE:     n_state = slot_free ? ST_IDLE : ST_DONE;
            default:     n_state = ST_INIT;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        case (r_state)
            ST_INIT:     o_ctl.clr_wr     = 1'b1;
            ST_IDLE:     o_ctl.load       = i_in_valid;
            ST_CLEAR:    o_ctl.clr_wr     = 1'b1;
            ST_LO_RD:    o_ctl.lo_rd      = i_stat.lo_need;
            ST_LO_WR:    o_ctl.lo_wr      = 1'b1;
            ST_HI_RD:    o_ctl.hi_rd      = i_stat.hi_need;
            ST_HI_WR:    o_ctl.hi_wr      = 1'b1;
            ST_NEXT_COL: o_ctl.col_step   = !i_stat.col_last;
            ST_RD_ISSUE: o_ctl.rd_issue   = 1'b1;
            ST_RD_WAIT:  o_ctl.rd_capture = 1'b1;
            ST_DONE:     o_ctl.finish     = slot_free;
            default:     o_ctl = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_DISPATCH))
        else $error("accepted beat not dispatched");
    a_reset_init: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == ST_INIT))
        else $error("reset did not start clear pass");
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.finish |=> o_out_valid)
        else $error("finished result not presented");
    a_no_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !(o_ctl.clr_wr || o_ctl.lo_wr || o_ctl.hi_wr))
        else $error("store written while idle");
`endif

endmodule

// File: src/pfb_datapath.sv
// Datapath: latched command, cursor, column walker, frame store and result beat.
// Depends on pfb_pkg and pfb_ram.
`timescale 1ns / 1ps

module pfb_datapath
    import pfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_dp_ctrl  i_ctl,
    output t_dp_stat  o_stat,
    output t_out_item o_out_item
);

    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE = SCREEN_WIDTH * PAGES;
    localparam int AW    = $clog2(STORE);

    t_cmd       r_cmd;
    logic [7:0] r_ox, r_oy, r_tcol, r_trow;
    logic       r_halt;
    logic [4:0] r_slot;
    logic [1:0] r_sel;
    logic [9:0] r_idx;
    logic [2:0] r_col, r_last_col;
    logic       r_has_draw;
    logic [AW-1:0] r_clr_cnt;
    logic [7:0] r_rd;
    t_out_item  r_out;

    logic [5:0]  slot_in;
    logic [7:0]  col_byte, xc;
    logic [15:0] sh;
    logic [4:0]  pg_lo, pg_hi;
    logic [7:0]  lo_bits, hi_bits;
    logic        x_in;
    logic [AW-1:0] addr_lo, addr_hi, raddr, waddr;
    logic [7:0]  rdata, wdata;
    logic        re, we;
    logic        clr_last;

    function automatic logic [7:0] page_mask(input logic [4:0] pg);
        logic [7:0] m;
        for (int b = 0; b < 8; b++) begin
            m[b] = (int'({pg, 3'(b)}) < SCREEN_HEIGHT);
        end
        return m;
    endfunction

    // draw origin: print uses the cursor
    assign slot_in = glyph_slot(i_in_item.char_code);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_in_item.cmd;
            r_slot <= slot_in[4:0];
            r_sel  <= i_in_item.symbol_sel;
            r_idx  <= i_in_item.byte_index;
            r_col  <= 3'd0;
            if (i_in_item.cmd == CMD_PRINT) begin
                r_ox <= r_tcol;
                r_oy <= r_trow;
            end else begin
                r_ox <= i_in_item.x_pos;
                r_oy <= i_in_item.y_pos;
            end
            case (i_in_item.cmd)
                CMD_PIXEL: begin
                    r_has_draw <= 1'b1;
                    r_last_col <= 3'd0;
                end
                CMD_GLYPH: begin
                    r_has_draw <= slot_in[5];
                    r_last_col <= 3'd4;
                end
                CMD_PRINT: begin
                    r_has_draw <= slot_in[5] && !r_halt;
                    r_last_col <= 3'd4;
                end
                CMD_SYMBOL: begin
                    r_has_draw <= (i_in_item.symbol_sel != 2'd3);
                    r_last_col <= 3'd7;
                end
                default: begin
                    r_has_draw <= 1'b0;
                    r_last_col <= 3'd0;
                end
            endcase
        end else if (i_ctl.col_step) begin
            r_col <= r_col + 3'd1;
        end
        if (i_ctl.rd_capture) begin
            r_rd <= (int'(r_idx) < STORE) ? rdata : 8'd0;
        end
    end

    // cursor and clear counter
    logic [7:0] adv_col, adv_row;
    logic       wrap;

    assign adv_col = r_tcol + 8'd6;
    assign adv_row = r_trow + 8'd9;
    assign wrap    = int'(adv_col) > (SCREEN_WIDTH - 6);

    logic [7:0] n_tcol, n_trow;
    logic       n_halt;

    always_comb begin
        n_tcol = r_tcol;
        n_trow = r_trow;
        n_halt = r_halt;
        if (r_cmd == CMD_CURSOR) begin
            n_tcol = r_ox;
            n_trow = r_oy;
            n_halt = 1'b0;
        end else if (r_cmd == CMD_PRINT && !r_halt) begin
            if (wrap) begin
                n_tcol = 8'd0;
                n_trow = adv_row;
                n_halt = int'(adv_row) > (SCREEN_HEIGHT - 8);
            end else begin
                n_tcol = adv_col;
            end
        end
    end

    assign clr_last = (r_clr_cnt == AW'(STORE - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcol    <= 8'd0;
            r_trow    <= 8'd0;
            r_halt    <= 1'b0;
            r_clr_cnt <= '0;
        end else begin
            if (i_ctl.finish) begin
                r_tcol <= n_tcol;
                r_trow <= n_trow;
                r_halt <= n_halt;
            end
            if (i_ctl.clr_wr) begin
                r_clr_cnt <= clr_last ? '0 : (r_clr_cnt + AW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_out.read_data   <= (r_cmd == CMD_READ) ? r_rd : 8'd0;
            r_out.cursor_col  <= n_tcol;
            r_out.cursor_row  <= n_trow;
            r_out.text_halted <= n_halt;
        end
    end

    // column byte, shifted across the two pages it can touch
    always_comb begin
        case (r_cmd)
            CMD_PIXEL:  col_byte = 8'h01;
            CMD_GLYPH,
            CMD_PRINT:  col_byte = glyph_col(r_slot, r_col);
            CMD_SYMBOL: col_byte = sym_col(r_sel, r_col);
            default:    col_byte = 8'h00;
        endcase
    end

    assign xc      = r_ox + {5'd0, r_col};
    assign x_in    = int'(xc) < SCREEN_WIDTH;
    assign sh      = {8'd0, col_byte} << r_oy[2:0];
    assign pg_lo   = r_oy[7:3];
    assign pg_hi   = pg_lo + 5'd1;
    assign lo_bits = sh[7:0]  & page_mask(pg_lo);
    assign hi_bits = sh[15:8] & page_mask(pg_hi);
    assign addr_lo = AW'(int'(xc) + int'(pg_lo) * SCREEN_WIDTH);
    assign addr_hi = AW'(int'(xc) + int'(pg_hi) * SCREEN_WIDTH);

    always_comb begin
        raddr = addr_lo;
        if (i_ctl.hi_rd) begin
            raddr = addr_hi;
        end else if (i_ctl.rd_issue) begin
            raddr = AW'(r_idx);
        end
        waddr = addr_lo;
        wdata = lo_bits | rdata;
        if (i_ctl.clr_wr) begin
            waddr = r_clr_cnt;
            wdata = 8'd0;
        end else if (i_ctl.hi_wr) begin
            waddr = addr_hi;
            wdata = hi_bits | rdata;
        end
    end

    assign re = i_ctl.lo_rd || i_ctl.hi_rd || i_ctl.rd_issue;
    assign we = i_ctl.clr_wr || i_ctl.lo_wr || i_ctl.hi_wr;

    pfb_ram #(
        .WIDTH (8),
        .DEPTH (STORE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_stat.cmd      = r_cmd;
    assign o_stat.has_draw = r_has_draw;
    assign o_stat.clr_last = clr_last;
    assign o_stat.lo_need  = x_in && (lo_bits != 8'd0);
    assign o_stat.hi_need  = x_in && (hi_bits != 8'd0);
    assign o_stat.col_last = (r_col == r_last_col);
    assign o_out_item      = r_out;

endmodule
